### rtl/dbs_pkg.sv
// Shared types and constants for the decayed boundary selector.
package dbs_pkg;

   localparam int MAX_BOUNDARIES     = 4096;
   localparam int MAX_SENTENCES      = 1024;
   localparam int MAX_UTT_BOUNDARIES = 255;
   localparam int WEIGHT_FRAC_BITS   = 16;

   typedef enum logic [1:0] {
      REQ_APPEND = 2'd0,
      REQ_SAMPLE = 2'd1,
      REQ_LOAD   = 2'd2,
      REQ_NONE   = 2'd3
   } req_type_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_APP_RD,
      ST_APP_ACC,
      ST_SMP_MUL,
      ST_SMP_RD,
      ST_SMP_CMP,
      ST_HIST_RD,
      ST_HIST_WR,
      ST_LOC_RD,
      ST_LOC_CMP,
      ST_RESP
   } state_type;

   localparam int CUM_W = 29;
   localparam logic [CUM_W-1:0] CUM_MAX = '1;

endpackage

### rtl/dbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/decayed_boundary_selector_core.sv
// Top level of the decayed boundary selector.
//
// Channels: the req_ channel carries one request beat (append, sample, load);
// the rsp_ channel returns exactly one result beat for each request, in order.
// A load writes one decay weight. An append reads the weights of its new
// offsets one per cycle. A sample multiplies the fraction by the cumulative
// weight, walks the weight bins from offset 0 one per cycle, bumps the
// histogram with a read and a write, then walks the utterance list from the
// newest back, with a length read and then a compare for each entry.
// One request is handled at a time; req_ready is high only while idle.
// After reset the block sweeps all MAX_BOUNDARIES + 1 histogram entries to
// zero, one entry a cycle, and accepts no request meanwhile.
// When the receiver stalls, the result beat holds in the output register;
// the next request is still taken and worked on, and its result waits in
// the last step until the output register frees.
module decayed_boundary_selector_core
   import dbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_utt_boundaries,
   input  logic [15:0] req_random_fraction,
   input  logic [11:0] req_weight_index,
   input  logic [16:0] req_weight_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [12:0] rsp_boundary_index,
   output logic [9:0]  rsp_sentence_index,
   output logic [7:0]  rsp_position_in_sentence,
   output logic [15:0] rsp_sample_count
);

   localparam int WA = $clog2(MAX_BOUNDARIES);
   localparam int HD = MAX_BOUNDARIES + 1;
   localparam int HA = $clog2(HD);
   localparam int SA = $clog2(MAX_SENTENCES);
   localparam int BW = $clog2(MAX_BOUNDARIES + 1);   // boundary count width
   localparam int CW = $clog2(MAX_SENTENCES + 1);    // sentence count width
   localparam int PW = 48;                           // product and run width

   state_type state_ff, state_in;

   logic [CUM_W-1:0] cum_ff, cum_in;
   logic [BW-1:0]    total_ff, total_in;
   logic [CW-1:0]    scount_ff, scount_in;
   logic [BW-1:0]    idx_ff, idx_in;       // bin or offset walker
   logic [BW-1:0]    end_ff, end_in;       // append end offset
   logic [CW-1:0]    sidx_ff, sidx_in;     // utterance walker
   logic [BW-1:0]    num_ff, num_in;
   logic [PW-1:0]    target_ff, target_in;
   logic [PW-1:0]    run_ff, run_in;
   logic [BW-1:0]    bsel_ff, bsel_in;
   logic [HA-1:0]    clr_ff, clr_in;
   logic [15:0]      frac_ff, frac_in;
   logic [7:0]       utt_ff, utt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        st_ff, st_in;
   logic [12:0] bi_ff, bi_in;
   logic [9:0]  si_ff, si_in;
   logic [7:0]  pi_ff, pi_in;
   logic [15:0] sc_ff, sc_in;

   // output register, separate from the working fields
   logic        out_st_ff, out_st_in;
   logic [12:0] out_bi_ff, out_bi_in;
   logic [9:0]  out_si_ff, out_si_in;
   logic [7:0]  out_pi_ff, out_pi_in;
   logic [15:0] out_sc_ff, out_sc_in;

   // weight RAM
   logic          w_we;
   logic [WA-1:0] w_wa, w_ra;
   logic [16:0]   w_rd;
   // length RAM
   logic          l_we;
   logic [SA-1:0] l_wa, l_ra;
   logic [7:0]    l_rd;
   // histogram RAM
   logic          h_we;
   logic [HA-1:0] h_wa, h_ra;
   logic [15:0]   h_wd, h_rd;

   dbs_ram #(.WIDTH(17), .DEPTH(MAX_BOUNDARIES)) u_weight (
      .clock(clock), .wr_en(w_we), .wr_addr(w_wa), .wr_data(req_weight_value),
      .rd_addr(w_ra), .rd_data(w_rd));

   dbs_ram #(.WIDTH(8), .DEPTH(MAX_SENTENCES)) u_length (
      .clock(clock), .wr_en(l_we), .wr_addr(l_wa), .wr_data(utt_ff),
      .rd_addr(l_ra), .rd_data(l_rd));

   dbs_ram #(.WIDTH(16), .DEPTH(HD)) u_hist (
      .clock(clock), .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd),
      .rd_addr(h_ra), .rd_data(h_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cum_ff       <= '0;
         total_ff     <= '0;
         scount_ff    <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cum_ff       <= cum_in;
         total_ff     <= total_in;
         scount_ff    <= scount_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff    <= idx_in;
      end_ff    <= end_in;
      sidx_ff   <= sidx_in;
      num_ff    <= num_in;
      target_ff <= target_in;
      run_ff    <= run_in;
      bsel_ff   <= bsel_in;
      frac_ff   <= frac_in;
      utt_ff    <= utt_in;
      st_ff     <= st_in;
      bi_ff     <= bi_in;
      si_ff     <= si_in;
      pi_ff     <= pi_in;
      sc_ff     <= sc_in;
      out_st_ff <= out_st_in;
      out_bi_ff <= out_bi_in;
      out_si_ff <= out_si_in;
      out_pi_ff <= out_pi_in;
      out_sc_ff <= out_sc_in;
   end

   logic [CUM_W:0]   cum_sum;
   logic [PW-1:0]    run_next;
   logic [BW-1:0]    base;
   logic [BW:0]      app_end;
   logic             app_bad;
   logic [CW-1:0]    scount_inc;

   always_comb begin
      state_in     = state_ff;
      cum_in       = cum_ff;
      total_in     = total_ff;
      scount_in    = scount_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      sidx_in      = sidx_ff;
      num_in       = num_ff;
      target_in    = target_ff;
      run_in       = run_ff;
      bsel_in      = bsel_ff;
      clr_in       = clr_ff;
      frac_in      = frac_ff;
      utt_in       = utt_ff;
      rsp_valid_in = rsp_valid_ff;
      st_in        = st_ff;
      bi_in        = bi_ff;
      si_in        = si_ff;
      pi_in        = pi_ff;
      sc_in        = sc_ff;
      out_st_in    = out_st_ff;
      out_bi_in    = out_bi_ff;
      out_si_in    = out_si_ff;
      out_pi_in    = out_pi_ff;
      out_sc_in    = out_sc_ff;
      req_ready    = 1'b0;
      w_we = 1'b0;
      w_wa = req_weight_index[WA-1:0];
      w_ra = idx_ff[WA-1:0];
      l_we = 1'b0;
      l_wa = scount_ff[SA-1:0];
      l_ra = sidx_ff[SA-1:0];
      h_we = 1'b0;
      h_wa = clr_ff;
      h_wd = '0;
      h_ra = bsel_ff[HA-1:0];

      cum_sum    = {1'b0, cum_ff} + (CUM_W+1)'(w_rd);
      run_next   = run_ff + PW'(w_rd);
      base       = (num_ff >= BW'(l_rd)) ? num_ff - BW'(l_rd) : '0;
      app_end    = (BW+1)'(total_ff) + (BW+1)'(req_utt_boundaries);
      app_bad    = (32'(req_utt_boundaries) > MAX_UTT_BOUNDARIES)
                   || (32'(scount_ff) >= MAX_SENTENCES)
                   || (32'(app_end) > MAX_BOUNDARIES);
      scount_inc = scount_ff + CW'(1);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            // zero the histogram, one entry a cycle
            h_we   = 1'b1;
            clr_in = clr_ff + HA'(1);
            if (32'(clr_ff) == HD - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_ready) begin
               st_in = 1'b0;
               bi_in = '0;
               si_in = '0;
               pi_in = '0;
               sc_in = '0;
               frac_in = req_random_fraction;
               utt_in  = req_utt_boundaries;
               case (req_type_type'(req_type))
                  REQ_APPEND: begin
                     if (app_bad) begin
                        st_in    = 1'b1;
                        state_in = ST_RESP;
                     end else begin
                        idx_in   = total_ff;
                        end_in   = app_end[BW-1:0];
                        state_in = ST_APP_RD;
                     end
                  end
                  REQ_SAMPLE: state_in = ST_SMP_MUL;
                  REQ_LOAD: begin
                     w_we     = (32'(req_weight_index) < MAX_BOUNDARIES);
                     state_in = ST_RESP;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_APP_RD: begin
            // record the length, then start reading offsets
            l_we      = 1'b1;
            scount_in = scount_inc;
            if (idx_ff == end_ff) begin
               total_in = end_ff;
               state_in = ST_RESP;
            end else begin
               idx_in   = idx_ff + BW'(1);
               state_in = ST_APP_ACC;
            end
         end
         ST_APP_ACC: begin
            // accumulate the weight read last cycle, issue the next read
            cum_in = cum_sum[CUM_W] ? CUM_MAX : cum_sum[CUM_W-1:0];
            if (idx_ff == end_ff) begin
               total_in = end_ff;
               state_in = ST_RESP;
            end else begin
               idx_in = idx_ff + BW'(1);
            end
         end
         ST_SMP_MUL: begin
            target_in = PW'(frac_ff) * PW'(cum_ff);
            run_in    = '0;
            idx_in    = '0;
            bsel_in   = '0;
            state_in  = (total_ff == '0) ? ST_HIST_RD : ST_SMP_RD;
         end
         ST_SMP_RD: begin
            // weight address idx_ff is being read
            state_in = ST_SMP_CMP;
         end
         ST_SMP_CMP: begin
            if ((run_ff << 16) <= target_ff && target_ff < (run_next << 16)) begin
               bsel_in  = total_ff - idx_ff;
               state_in = ST_HIST_RD;
            end else if (idx_ff + BW'(1) == total_ff) begin
               state_in = ST_HIST_RD;
            end else begin
               run_in = run_next;
               idx_in = idx_ff + BW'(1);
               w_ra   = idx_in[WA-1:0];
               // read issued this cycle, compared next cycle
            end
         end
         ST_HIST_RD: begin
            state_in = ST_HIST_WR;
         end
         ST_HIST_WR: begin
            h_we  = 1'b1;
            h_wa  = bsel_ff[HA-1:0];
            h_wd  = (h_rd == 16'hFFFF) ? h_rd : h_rd + 16'd1;
            sc_in = h_wd;
            bi_in = 13'(bsel_ff);
            num_in  = total_ff;
            sidx_in = scount_ff - CW'(1);
            state_in = (scount_ff == '0) ? ST_RESP : ST_LOC_RD;
         end
         ST_LOC_RD: begin
            state_in = ST_LOC_CMP;
         end
         ST_LOC_CMP: begin
            if (bsel_ff > base) begin
               si_in    = 10'(sidx_ff);
               pi_in    = 8'(BW'(l_rd) - (num_ff - bsel_ff));
               state_in = ST_RESP;
            end else if (sidx_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               sidx_in  = sidx_ff - CW'(1);
               num_in   = base;
               l_ra     = sidx_in[SA-1:0];
               state_in = ST_LOC_RD;
            end
         end
         ST_RESP: begin
            // hold until the output register is free or being drained
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_st_in    = st_ff;
               out_bi_in    = bi_ff;
               out_si_in    = si_ff;
               out_pi_in    = pi_ff;
               out_sc_in    = sc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_status               = out_st_ff;
   assign rsp_boundary_index       = out_bi_ff;
   assign rsp_sentence_index       = out_si_ff;
   assign rsp_position_in_sentence = out_pi_ff;
   assign rsp_sample_count         = out_sc_ff;

endmodule
